### rtl/core/pidfda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidfda_pkg - shared definitions for the filtered-derivative PID controller
// Widths, scaling constants, register indexes, sequencer states and the
// saturation and scaling helpers used by the controller datapath.
// ----------------------------------------------------------------------------
package pidfda_pkg;

  // Field and datapath widths
  localparam int DATA_W   = 32;          // Q16.16 values
  localparam int MS_W     = 16;          // elapsed milliseconds
  localparam int ALPHA_W  = 17;          // smoothing factor, Q1.16
  localparam int BOUND_W  = 31;          // integral clamp
  localparam int CFG_AW   = 3;           // register index
  localparam int OP_W     = 34;          // multiplier operand, signed
  localparam int PROD_W   = 64;          // kept product bits
  localparam int DVD_W    = 48;          // divider dividend magnitude
  localparam int DVS_W    = 17;          // divider divisor
  localparam int QUO_W    = DVD_W + 1;   // signed quotient
  localparam int TERM_W   = PROD_W - 16; // product scaled by 2^-16
  localparam int ACC_W    = 50;          // sum of three scaled terms
  localparam int DIV_CYCLES = DVD_W / 2; // two quotient bits per cycle
  localparam int CNT_W    = $clog2(DIV_CYCLES);

  // Scaling constants
  localparam logic [DVS_W-1:0] MS_PER_S    = 17'd1000;    // ms per second
  localparam logic [DVS_W-1:0] ZERO_MS_DIV = 17'd100000;  // 1 / 0.00001 s

  // Register reset values
  localparam logic [DATA_W-1:0]  FLOOR_RST  = 32'h8000_0000;
  localparam logic [DATA_W-1:0]  CEIL_RST   = 32'h7FFF_FFFF;
  localparam logic [ALPHA_W-1:0] ALPHA_RST  = 17'd6554;       // about 0.1
  localparam logic [BOUND_W-1:0] WINDUP_RST = 31'd131072000;  // 2000.0

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_I    = 3'd1,
    CFG_GAIN_D    = 3'd2,
    CFG_TARGET    = 3'd3,
    CFG_FLOOR     = 3'd4,
    CFG_CEILING   = 3'd5,
    CFG_ALPHA     = 3'd6,
    CFG_WINDUP    = 3'd7
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_INC,
    ST_DIV_INC_LD,
    ST_DIV_INC,
    ST_INTEG,
    ST_MUL_RAW,
    ST_DIV_RAW_LD,
    ST_DIV_RAW,
    ST_RAW,
    ST_MUL_FILT,
    ST_FILT,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC_D,
    ST_OUT
  } pid_state_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[DATA_W-1:0];
  endfunction

  // Divide a product by 65536, rounding toward zero
  function automatic logic signed [TERM_W-1:0] trunc16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + (p[PROD_W-1] ? 64'sd65535 : 64'sd0);
    return t[PROD_W-1:16];
  endfunction

endpackage

### rtl/core/pid_filtered_derivative_antiwindup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_filtered_derivative_antiwindup - PID controller, Q16.16
// Anti-windup integral, low-pass filtered derivative, clamped drive output.
// ----------------------------------------------------------------------------
// One item (measurement plus elapsed ms) gives one clamped drive value. A
// small sequencer runs every step through one shared 34x34 multiplier and
// one shared divider that retires two quotient bits per cycle. An item with
// nonzero elapsed_ms runs two divisions plus the multiply and update steps
// before its result is presented; with elapsed_ms zero the derivative
// division is skipped. in_tready is high only while the sequencer is idle.
// The result sits in an output register, so a new item can be taken while
// the previous one waits; the next result waits for out_tready in turn.
// Configuration writes take effect at once and are meant for idle periods.
module pid_filtered_derivative_antiwindup
  import pidfda_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // configuration write port
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [DATA_W-1:0]   cfg_wdata,
  // input items
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [47:0]         in_tdata,   // [31:0] measured_value, [47:32] elapsed_ms
  // result items
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [DATA_W-1:0]   out_tdata,  // [31:0] control_output
  output logic                out_tuser   // [0] output_clamped
);

  // Configuration registers
  logic signed [DATA_W-1:0] gain_p_r, gain_i_r, gain_d_r, target_r;
  logic signed [DATA_W-1:0] floor_r, ceil_r;
  logic [ALPHA_W-1:0]       alpha_r;
  logic [BOUND_W-1:0]       windup_r;

  // Controller state
  logic signed [DATA_W-1:0] integral_sum_r, last_error_r, slope_r;

  // Sequencer
  pid_state_t               state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r;

  // Per-item working registers
  logic signed [DATA_W-1:0] meas_r, e_r, raw_r;
  logic [MS_W-1:0]          ms_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [DVD_W-1:0]         dvd_r;
  logic [DVS_W-1:0]         dvs_r;
  logic [DVS_W-1:0]         rem_r;
  logic                     div_neg_r;
  logic                     out_tvalid_r;
  logic [DATA_W-1:0]        out_data_r;
  logic                     out_clamp_r;

  // Combinational datapath
  logic                     ms_zero, out_free;
  logic signed [DATA_W:0]   e_diff, err_delta, slope_delta;
  logic signed [OP_W-1:0]   mul_a, mul_b;
  logic signed [2*OP_W-1:0] mul_full;
  logic signed [PROD_W-1:0] prod_abs;
  logic [DVD_W-1:0]         dvd_v;
  logic [DVS_W-1:0]         rem_v;
  logic [DVS_W:0]           trial;
  logic                     qbit;
  logic signed [QUO_W-1:0]  quo_s;
  logic signed [ACC_W-1:0]  integ_sum, bound_pos, bound_neg, integ_c;
  logic signed [63:0]       filt_sum;
  logic signed [ACC_W-1:0]  ceil_x, floor_x, res_hi, res;
  logic                     hit_hi, hit_lo;

  assign ms_zero  = (ms_r == '0);
  assign out_free = !out_tvalid_r || out_tready;

  // Error, error change and filter difference
  assign e_diff      = {target_r[DATA_W-1], target_r} - {meas_r[DATA_W-1], meas_r};
  assign err_delta   = {e_r[DATA_W-1], e_r} - {last_error_r[DATA_W-1], last_error_r};
  assign slope_delta = {raw_r[DATA_W-1], raw_r} - {slope_r[DATA_W-1], slope_r};

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:       if (in_tvalid) state_nxt = ST_ERR;
      ST_ERR:        state_nxt = ST_MUL_INC;
      ST_MUL_INC:    state_nxt = ST_DIV_INC_LD;
      ST_DIV_INC_LD: state_nxt = ST_DIV_INC;
      ST_DIV_INC:    if (cnt_r == '0) state_nxt = ST_INTEG;
      ST_INTEG:      state_nxt = ST_MUL_RAW;
      ST_MUL_RAW:    state_nxt = ST_DIV_RAW_LD;
      ST_DIV_RAW_LD: state_nxt = ms_zero ? ST_MUL_FILT : ST_DIV_RAW;
      ST_DIV_RAW:    if (cnt_r == '0) state_nxt = ST_RAW;
      ST_RAW:        state_nxt = ST_MUL_FILT;
      ST_MUL_FILT:   state_nxt = ST_FILT;
      ST_FILT:       state_nxt = ST_MUL_P;
      ST_MUL_P:      state_nxt = ST_MUL_I;
      ST_MUL_I:      state_nxt = ST_MUL_D;
      ST_MUL_D:      state_nxt = ST_ACC_D;
      ST_ACC_D:      state_nxt = ST_OUT;
      ST_OUT:        if (out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // Output decode: handshake and multiplier operand select
  always_comb begin
    in_tready = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_MUL_INC: begin
        mul_a = OP_W'(e_r);
        mul_b = ms_zero ? OP_W'(1) : $signed({{(OP_W-MS_W){1'b0}}, ms_r});
      end
      ST_MUL_RAW: begin
        mul_a = OP_W'(err_delta);
        mul_b = $signed({{(OP_W-DVS_W){1'b0}}, (ms_zero ? ZERO_MS_DIV : MS_PER_S)});
      end
      ST_MUL_FILT: begin
        mul_a = $signed({{(OP_W-ALPHA_W){1'b0}}, alpha_r});
        mul_b = OP_W'(slope_delta);
      end
      ST_MUL_P: begin
        mul_a = OP_W'(gain_p_r);
        mul_b = OP_W'(e_r);
      end
      ST_MUL_I: begin
        mul_a = OP_W'(gain_i_r);
        mul_b = OP_W'(integral_sum_r);
      end
      ST_MUL_D: begin
        mul_a = OP_W'(gain_d_r);
        mul_b = OP_W'(slope_r);
      end
      default: ;
    endcase
  end

  // Shared multiplier
  assign mul_full = mul_a * mul_b;
  assign prod_abs = prod_r[PROD_W-1] ? -prod_r : prod_r;

  // Shared divider: two restoring steps per cycle
  always_comb begin
    rem_v = rem_r;
    dvd_v = dvd_r;
    trial = '0;
    qbit  = 1'b0;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_v, dvd_v[DVD_W-1]};
      qbit  = (trial >= {1'b0, dvs_r});
      if (qbit) begin
        trial = trial - {1'b0, dvs_r};
      end
      rem_v = trial[DVS_W-1:0];
      dvd_v = {dvd_v[DVD_W-2:0], qbit};
    end
  end

  assign quo_s = div_neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});

  // Integral update with windup clamp
  assign integ_sum = ACC_W'(integral_sum_r) + ACC_W'(quo_s);
  assign bound_pos = $signed({{(ACC_W-BOUND_W){1'b0}}, windup_r});
  assign bound_neg = -bound_pos;
  always_comb begin
    if (integ_sum > bound_pos) begin
      integ_c = bound_pos;
    end else if (integ_sum < bound_neg) begin
      integ_c = bound_neg;
    end else begin
      integ_c = integ_sum;
    end
  end

  // Derivative filter
  assign filt_sum = 64'(slope_r) + 64'(trunc16(prod_r));

  // Output clamp: ceiling first, floor wins
  assign ceil_x  = ACC_W'(ceil_r);
  assign floor_x = ACC_W'(floor_r);
  assign hit_hi  = (acc_r > ceil_x);
  assign res_hi  = hit_hi ? ceil_x : acc_r;
  assign hit_lo  = (res_hi < floor_x);
  assign res     = hit_lo ? floor_x : res_hi;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DIV_INC_LD || state_r == ST_DIV_RAW_LD) begin
        cnt_r <= CNT_W'(DIV_CYCLES - 1);
      end else if (state_r == ST_DIV_INC || state_r == ST_DIV_RAW) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (state_r == ST_OUT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Configuration and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r       <= '0;
      gain_i_r       <= '0;
      gain_d_r       <= '0;
      target_r       <= '0;
      floor_r        <= FLOOR_RST;
      ceil_r         <= CEIL_RST;
      alpha_r        <= ALPHA_RST;
      windup_r       <= WINDUP_RST;
      integral_sum_r <= '0;
      last_error_r   <= '0;
      slope_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_GAIN_P:  gain_p_r <= cfg_wdata;
          CFG_GAIN_I:  gain_i_r <= cfg_wdata;
          CFG_GAIN_D:  gain_d_r <= cfg_wdata;
          CFG_TARGET:  target_r <= cfg_wdata;
          CFG_FLOOR:   floor_r  <= cfg_wdata;
          CFG_CEILING: ceil_r   <= cfg_wdata;
          CFG_ALPHA:   alpha_r  <= cfg_wdata[ALPHA_W-1:0];
          CFG_WINDUP:  windup_r <= cfg_wdata[BOUND_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_INTEG) begin
        integral_sum_r <= integ_c[DATA_W-1:0];
      end
      if (state_r == ST_FILT) begin
        slope_r      <= sat32(filt_sum);
        last_error_r <= e_r;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    prod_r <= mul_full[PROD_W-1:0];
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          meas_r <= in_tdata[DATA_W-1:0];
          ms_r   <= in_tdata[DATA_W+MS_W-1:DATA_W];
        end
      end
      ST_ERR: e_r <= sat32(64'(e_diff));
      ST_DIV_INC_LD: begin
        dvd_r     <= prod_abs[DVD_W-1:0];
        div_neg_r <= prod_r[PROD_W-1];
        dvs_r     <= ms_zero ? ZERO_MS_DIV : MS_PER_S;
        rem_r     <= '0;
      end
      ST_DIV_RAW_LD: begin
        dvd_r     <= prod_abs[DVD_W-1:0];
        div_neg_r <= prod_r[PROD_W-1];
        dvs_r     <= {1'b0, ms_r};
        rem_r     <= '0;
        // zero elapsed time: the product already is the raw slope
        if (ms_zero) begin
          raw_r <= sat32(prod_r);
        end
      end
      ST_DIV_INC, ST_DIV_RAW: begin
        dvd_r <= dvd_v;
        rem_r <= rem_v;
      end
      ST_RAW:   raw_r <= sat32(64'(quo_s));
      ST_MUL_P: acc_r <= '0;
      ST_MUL_I, ST_MUL_D, ST_ACC_D: acc_r <= acc_r + ACC_W'(trunc16(prod_r));
      ST_OUT: begin
        if (out_free) begin
          out_data_r  <= res[DATA_W-1:0];
          out_clamp_r <= hit_hi | hit_lo;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clamp_r;

endmodule

### rtl/core/pidfda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidfda_checker - port-level checks for the PID controller
// Watches the item handshakes: one result per item, busy after an
// accepted item, quiet after reset, held result while stalled.
// ----------------------------------------------------------------------------
module pidfda_checker
  import pidfda_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                cfg_we,
  input logic [CFG_AW-1:0]   cfg_addr,
  input logic [DATA_W-1:0]   cfg_wdata,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic [47:0]         in_tdata,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [DATA_W-1:0]   out_tdata,
  input logic                out_tuser
);

  // Items taken in but whose result is not yet taken (at most two)
  logic [1:0] pending_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_acc && !out_acc) begin
      pending_r <= pending_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  // A result is only shown for an item that was taken in
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pending_r != 2'd0)
    else $error("result without an outstanding item");

  // The sequencer is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("item accepted while previous one still in work");

  // Reset leaves no result pending
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind pid_filtered_derivative_antiwindup pidfda_checker u_pidfda_checker (.*);

### verif/tb_pid_filtered_derivative_antiwindup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_filtered_derivative_antiwindup - self-checking bench for the PID core
// Streams measurement items through the controller under a series of gain,
// limit, filter and windup settings and checks every drive value and clamp
// flag against a cycle-free model of the Q16.16 control law.
// ----------------------------------------------------------------------------
module tb_pid_filtered_derivative_antiwindup;
  import pidfda_pkg::*;

  localparam int          RANDOM_ITEMS = 1250;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 80;
  localparam logic [31:0] Q_MAX        = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN        = 32'h8000_0000;
  localparam logic [31:0] Q_ONE        = 32'h0001_0000;

  typedef struct packed {
    logic [31:0] drive;
    logic        clamped;
  } drive_result_t;

  // Model of the control law plus the queue of drive values still due
  class drive_scoreboard;
    longint kp, ki, kd, setpoint, floor_lim, ceil_lim, alpha, bound;
    longint integ_acc, prev_err, slope_filt;
    drive_result_t drive_q[$];
    int errors;
    int checked;
    int clamped_seen;

    function new();
      kp = 0;
      ki = 0;
      kd = 0;
      setpoint = 0;
      floor_lim = longint'($signed(FLOOR_RST));
      ceil_lim = longint'($signed(CEIL_RST));
      alpha = longint'(ALPHA_RST);
      bound = longint'(WINDUP_RST);
      integ_acc = 0;
      prev_err = 0;
      slope_filt = 0;
      errors = 0;
      checked = 0;
      clamped_seen = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_GAIN_P:  kp = longint'($signed(v));
        CFG_GAIN_I:  ki = longint'($signed(v));
        CFG_GAIN_D:  kd = longint'($signed(v));
        CFG_TARGET:  setpoint = longint'($signed(v));
        CFG_FLOOR:   floor_lim = longint'($signed(v));
        CFG_CEILING: ceil_lim = longint'($signed(v));
        CFG_ALPHA:   alpha = longint'(v[ALPHA_W-1:0]);
        CFG_WINDUP:  bound = longint'(v[BOUND_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Advance the controller state by one measurement and queue its drive
    function void note_sample(logic [31:0] meas_bits, logic [15:0] ms_bits);
      longint meas, ms, err, inc, raw, filt, sum;
      drive_result_t want;
      meas = longint'($signed(meas_bits));
      ms = longint'(ms_bits);
      err = clip32(setpoint - meas);
      // zero elapsed time stands for 0.01 ms
      if (ms != 0) begin
        inc = (err * ms) / 1000;
        raw = clip32(((err - prev_err) * 1000) / ms);
      end else begin
        inc = err / 100000;
        raw = clip32((err - prev_err) * 100000);
      end
      // anti-windup clamp on the integral
      integ_acc = integ_acc + inc;
      if (integ_acc > bound) integ_acc = bound;
      else if (integ_acc < -bound) integ_acc = -bound;
      filt = clip32(slope_filt + (alpha * (raw - slope_filt)) / 65536);
      slope_filt = filt;
      prev_err = err;
      sum = (kp * err) / 65536 + (ki * integ_acc) / 65536 + (kd * filt) / 65536;
      // ceiling first, floor last so the floor wins when they cross
      want.clamped = 1'b0;
      if (sum > ceil_lim) begin
        sum = ceil_lim;
        want.clamped = 1'b1;
      end
      if (sum < floor_lim) begin
        sum = floor_lim;
        want.clamped = 1'b1;
      end
      want.drive = sum[31:0];
      drive_q.push_back(want);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    function void check_drive(logic [31:0] drive, logic clamped);
      drive_result_t want;
      checked++;
      if (clamped === 1'b1) clamped_seen++;
      if (drive_q.size() == 0) begin
        flag($sformatf("drive %h with nothing pending", drive));
        return;
      end
      want = drive_q.pop_front();
      if (drive !== want.drive)
        flag($sformatf("drive %h, model %h", drive, want.drive));
      if (clamped !== want.clamped)
        flag($sformatf("clamp flag %b, model %b", clamped, want.clamped));
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;

  drive_scoreboard sb;
  logic [31:0]     reg_val [8];
  bit              calm;          // no idling on either side in this stretch
  int              cycles;
  int              settings_used;

  pid_filtered_derivative_antiwindup DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d drive values pending", cycles, sb.pending());
      $display("tb_pid_filtered_derivative_antiwindup failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_near(int span);
    int v;
    v = $urandom_range(0, 2 * span);
    return v - span;
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return Q_MIN;
      1: return Q_MAX;
      2, 3: return $urandom;
      default: return pick_near(8 * 65536);
    endcase
  endfunction

  function automatic logic [31:0] pick_measure();
    case ($urandom_range(0, 9))
      0: return Q_MIN;
      1: return Q_MAX;
      2, 3: return $urandom;
      default: return reg_val[CFG_TARGET] + pick_near(50 * 65536);
    endcase
  endfunction

  function automatic logic [15:0] pick_ms();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return $urandom_range(0, 65535);
      default: return $urandom_range(1, 50);
    endcase
  endfunction

  // Offer one measurement item and wait for it to be taken
  task automatic send_sample(input logic [31:0] meas, input logic [15:0] ms);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ms, meas};
    do @(posedge clk); while (!in_tready);
    sb.note_sample(meas, ms);
  endtask

  // Let every pending drive value come out, then a short quiet spell
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all registers from reg_val while the core is idle
  task automatic load_regs();
    settle();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= cfg_idx_t'(i);
      cfg_wdata <= reg_val[i];
      @(posedge clk);
      sb.write_reg(cfg_idx_t'(i), reg_val[i]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic pick_settings();
    logic [31:0] lo, hi, t;
    reg_val[CFG_GAIN_P] = pick_gain();
    reg_val[CFG_GAIN_I] = pick_gain();
    reg_val[CFG_GAIN_D] = pick_gain();
    reg_val[CFG_TARGET] = ($urandom_range(0, 3) == 0) ? $urandom : pick_near(100 * 65536);
    lo = pick_near(200 * 65536);
    hi = lo + $urandom_range(0, 400 * 65536);
    case ($urandom_range(0, 7))
      0: begin
        lo = Q_MIN;
        hi = Q_MAX;
      end
      1: begin
        // crossed limits
        t = lo;
        lo = hi + Q_ONE;
        hi = t;
      end
      2: begin
        lo = $urandom;
        hi = $urandom;
      end
      default: ;
    endcase
    reg_val[CFG_FLOOR] = lo;
    reg_val[CFG_CEILING] = hi;
    case ($urandom_range(0, 7))
      0: reg_val[CFG_ALPHA] = 32'd0;
      1: reg_val[CFG_ALPHA] = 32'd65536;
      2: reg_val[CFG_ALPHA] = 32'd131071;
      3: reg_val[CFG_ALPHA] = $urandom_range(65537, 131071);
      default: reg_val[CFG_ALPHA] = $urandom_range(0, 65536);
    endcase
    case ($urandom_range(0, 7))
      0: reg_val[CFG_WINDUP] = 32'd0;
      1: reg_val[CFG_WINDUP] = {1'b0, {31{1'b1}}};
      2: reg_val[CFG_WINDUP] = {1'b0, $urandom} >> 1;
      default: reg_val[CFG_WINDUP] = $urandom_range(1, 3000 * 65536);
    endcase
  endtask

  // Result side: random back-pressure, check every item taken
  initial begin
    int stall;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_drive(out_tdata, out_tuser);
    end
  end

  initial begin
    int sent;
    int burst;
    sb = new();
    cycles <= 0;
    settings_used = 0;
    calm = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_GAIN_P;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    out_tready <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: all gains zero
    send_sample(32'd0, 16'd0);
    send_sample(Q_MAX, 16'hFFFF);
    send_sample(Q_MIN, 16'd0);

    // Moderate gains; drive the integral into both windup limits
    reg_val[CFG_GAIN_P] = Q_ONE;
    reg_val[CFG_GAIN_I] = 32'h0000_8000;
    reg_val[CFG_GAIN_D] = 32'd655;
    reg_val[CFG_TARGET] = 32'd10 << 16;
    reg_val[CFG_FLOOR] = -(32'd100 << 16);
    reg_val[CFG_CEILING] = 32'd100 << 16;
    reg_val[CFG_ALPHA] = 32'd6554;
    reg_val[CFG_WINDUP] = 32'd2000 << 16;
    load_regs();
    send_sample(32'd0, 16'd1);
    send_sample(32'd0, 16'd0);
    repeat (3) send_sample(Q_MIN, 16'hFFFF);
    repeat (3) send_sample(Q_MAX, 16'hFFFF);
    send_sample(32'd10 << 16, 16'd10);

    // Floor above ceiling, alpha at its top, no integral allowed
    reg_val[CFG_GAIN_P] = Q_MAX;
    reg_val[CFG_GAIN_I] = Q_MIN;
    reg_val[CFG_GAIN_D] = Q_MAX;
    reg_val[CFG_TARGET] = Q_MIN;
    reg_val[CFG_FLOOR] = 32'd5 << 16;
    reg_val[CFG_CEILING] = -(32'd5 << 16);
    reg_val[CFG_ALPHA] = 32'd131071;
    reg_val[CFG_WINDUP] = 32'd0;
    load_regs();
    send_sample(Q_MAX, 16'd0);
    send_sample(32'd0, 16'd1);
    send_sample(Q_MIN, 16'hFFFF);
    send_sample(32'd12345, 16'd7);

    // Opposite extremes, widest windup and unity filter
    reg_val[CFG_GAIN_P] = Q_MIN;
    reg_val[CFG_GAIN_I] = Q_MAX;
    reg_val[CFG_GAIN_D] = Q_MIN;
    reg_val[CFG_TARGET] = Q_MAX;
    reg_val[CFG_FLOOR] = Q_MIN;
    reg_val[CFG_CEILING] = Q_MAX;
    reg_val[CFG_ALPHA] = 32'd65536;
    reg_val[CFG_WINDUP] = {1'b0, {31{1'b1}}};
    load_regs();
    repeat (2) send_sample(Q_MIN, 16'hFFFF);
    send_sample(Q_MAX, 16'd0);
    send_sample(32'd0, 16'd1);

    // Random settings, each followed by a burst of measurements
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick_settings();
      load_regs();
      calm = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(80, 130);
      repeat (burst) send_sample(pick_measure(), pick_ms());
      sent += burst;
    end
    calm = 1'b0;

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.flag($sformatf("%0d drive values never came", sb.pending()));

    $display("covered %0d results under %0d register settings, %0d of them clamped",
             sb.checked, settings_used, sb.clamped_seen);
    $display("%0d mismatches in %0d cycles", sb.errors, cycles);
    if (sb.errors == 0) begin
      $display("tb_pid_filtered_derivative_antiwindup passed");
    end else begin
      $display("tb_pid_filtered_derivative_antiwindup failed");
    end
    $finish;
  end

endmodule
